@@ sv/fms_pkg.sv @@
package fms_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int PAT_AW      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int PAT_CW      = $clog2(PATTERN_MAX + 1);
    localparam int SCORE_W     = 32;
    localparam int SUM_W       = SCORE_W + 2;
    localparam int RUN_WEIGHT  = 10;

    localparam logic [7:0] SPACE_BYTE = 8'h20;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_STRING = 2'd2,
        OP_END    = 2'd3
    } t_opcode;

    typedef struct packed {
        logic              we;
        logic [PAT_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [PAT_AW-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic                      overflow;
        logic signed [SCORE_W-1:0] score;
        logic                      matched;
    } t_result;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

@@ sv/fms_pattern_mem.sv @@
module fms_pattern_mem (
    input  logic             i_clk,
    input  fms_pkg::t_mem_req i_req,
    output logic [7:0]       o_rdata
);
    import fms_pkg::*;

    logic [7:0] r_mem [PATTERN_MAX];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // write-first on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_req.we && i_req.waddr == i_req.raddr) begin
            r_rdata <= i_req.wdata;
        end else begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/fms_score_core.sv @@
module fms_score_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_text_byte,
    input  logic [7:0]        i_pat_byte,
    output fms_pkg::t_mem_req o_mem_req,
    output logic              o_res_valid,
    output fms_pkg::t_result  o_res
);
    import fms_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

    logic [PAT_CW-1:0]         r_len, n_len;
    logic                      r_ovf, n_ovf;
    logic [PAT_CW-1:0]         r_pos, n_pos;
    logic [PAT_CW-1:0]         r_run, n_run;
    logic signed [SCORE_W-1:0] r_score, n_score;

    t_opcode                   w_op;
    logic                      w_finished;
    logic                      w_space;
    logic                      w_hit;
    logic                      w_miss_case;
    logic [PAT_CW+3:0]         w_run_x10;
    logic [SUM_W-1:0]          w_delta;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [SCORE_W-1:0] w_sat;
    logic                      w_we;

    assign w_op        = t_opcode'(i_opcode);
    assign w_finished  = (r_pos >= r_len);
    assign w_space     = (i_text_byte == SPACE_BYTE);
    assign w_hit       = (fold_case(i_text_byte) == fold_case(i_pat_byte));
    assign w_miss_case = (i_text_byte != i_pat_byte);
    assign w_run_x10   = ({4'b0, r_run} << 3) + ({4'b0, r_run} << 1);

    always_comb begin
        if (w_finished) begin
            w_delta = -SUM_W'(1);
        end else if (w_hit) begin
            w_delta = SUM_W'(w_run_x10) - SUM_W'(w_miss_case);
        end else begin
            w_delta = -SUM_W'(RUN_WEIGHT);
        end
        w_sum = $signed({{2{r_score[SCORE_W-1]}}, r_score}) + $signed(w_delta);
        if (w_sum > SAT_MAX) begin
            w_sat = SAT_MAX[SCORE_W-1:0];
        end else if (w_sum < SAT_MIN) begin
            w_sat = SAT_MIN[SCORE_W-1:0];
        end else begin
            w_sat = w_sum[SCORE_W-1:0];
        end
    end

    always_comb begin
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_pos       = r_pos;
        n_run       = r_run;
        n_score     = r_score;
        w_we        = 1'b0;
        o_res_valid = 1'b0;
        if (i_accept) begin
            case (w_op)
                OP_CLEAR: begin
                    n_len   = '0;
                    n_ovf   = 1'b0;
                    n_pos   = '0;
                    n_run   = '0;
                    n_score = '0;
                end
                OP_APPEND: begin
                    if (!w_space) begin
                        if (r_len < PAT_CW'(PATTERN_MAX)) begin
                            w_we  = 1'b1;
                            n_len = r_len + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
                OP_STRING: begin
                    if (w_finished) begin
                        n_score = w_sat;
                    end else if (!w_space) begin
                        n_score = w_sat;
                        if (w_hit) begin
                            n_run = r_run + 1'b1;
                            n_pos = r_pos + 1'b1;
                        end else begin
                            n_run = '0;
                        end
                    end
                end
                OP_END: begin
                    o_res_valid = 1'b1;
                    n_pos       = '0;
                    n_run       = '0;
                    n_score     = '0;
                end
                default: begin
                    n_len = r_len;
                end
            endcase
        end
    end

    assign o_res.matched  = w_finished;
    assign o_res.score    = w_finished ? r_score : '0;
    assign o_res.overflow = r_ovf;

    assign o_mem_req.we    = w_we;
    assign o_mem_req.waddr = r_len[PAT_AW-1:0];
    assign o_mem_req.wdata = i_text_byte;
    // prefetch the pattern byte at the next match position
    assign o_mem_req.raddr = n_pos[PAT_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_pos   <= '0;
            r_run   <= '0;
            r_score <= '0;
        end else begin
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            r_pos   <= n_pos;
            r_run   <= n_run;
            r_score <= n_score;
        end
    end

    a_pos_in_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_len)
        else $error("match position beyond pattern length");

    a_run_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run <= r_pos)
        else $error("run longer than match position");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_len == PAT_CW'(PATTERN_MAX)))
        else $error("overflow flagged with room left");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_op == OP_END) |=> (r_pos == '0 && r_run == '0 && r_score == '0))
        else $error("match state not cleared after end of string");

endmodule

@@ sv/fms_out_buf.sv @@
module fms_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  fms_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output fms_pkg::t_result o_res
);
    import fms_pkg::*;

    logic    r_ovalid, n_ovalid;
    logic    r_svalid, n_svalid;
    t_result r_ores, n_ores;
    t_result r_sres, n_sres;

    always_comb begin
        n_ovalid = r_ovalid;
        n_svalid = r_svalid;
        n_ores   = r_ores;
        n_sres   = r_sres;
        if (!r_ovalid || i_ready) begin
            if (r_svalid) begin
                n_ovalid = 1'b1;
                n_ores   = r_sres;
                n_svalid = 1'b0;
            end else if (i_res_valid) begin
                n_ovalid = 1'b1;
                n_ores   = i_res;
            end else begin
                n_ovalid = 1'b0;
            end
        end else if (i_res_valid) begin
            n_svalid = 1'b1;
            n_sres   = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_svalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            r_svalid <= n_svalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ores <= n_ores;
        r_sres <= n_sres;
    end

    assign o_free  = !r_svalid;
    assign o_valid = r_ovalid;
    assign o_res   = r_ores;

endmodule

@@ sv/fuzzy_match_scorer_top.sv @@
// channel   dir  tdata             tuser
// s_axis    in   [7:0] text_byte   [1:0] opcode
// m_axis    out  [31:0] score      [0] matched, [1] pattern_overflow
//
// one item per cycle while s_axis tready is high; the pattern byte for the current match position is
// prefetched from the single-port-read pattern memory in the cycle before
// a result is registered into the output register, or into a skid register while m_axis is stalled
// reset clears the counters, overflow flag, score and output valid flags; the pattern memory needs no sweep
// s_axis tready drops only while a second result waits behind a stalled one
module fuzzy_match_scorer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // text_byte
    input  logic [1:0]  i_s_axis_tuser,  // opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // score
    output logic [1:0]  o_m_axis_tuser   // matched, pattern_overflow
);
    import fms_pkg::*;

    logic     w_accept;
    logic     w_free;
    logic     w_res_valid;
    logic [7:0] w_pat_byte;
    t_mem_req w_mem_req;
    t_result  w_res;
    t_result  w_out_res;

    assign o_s_axis_tready = w_free;
    assign w_accept        = i_s_axis_tvalid && w_free;

    fms_pattern_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_pat_byte)
    );

    fms_score_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_opcode    (i_s_axis_tuser),
        .i_text_byte (i_s_axis_tdata),
        .i_pat_byte  (w_pat_byte),
        .o_mem_req   (w_mem_req),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    fms_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_free      (w_free),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_res       (w_out_res)
    );

    assign o_m_axis_tdata = w_out_res.score;
    assign o_m_axis_tuser = {w_out_res.overflow, w_out_res.matched};

endmodule
